FILE: sv/annexb_nal_unit_splitter_macros.svh
`ifndef ANNEXB_NAL_UNIT_SPLITTER_MACROS_SVH
`define ANNEXB_NAL_UNIT_SPLITTER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ANBS_ASSERT_NOW(label, clk_i, rst_ni, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ANBS_ASSERT_NEXT(label, clk_i, rst_ni, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: sv/anbs_pkg.sv
`default_nettype none

package anbs_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_ONE  = 8'h01;
	localparam logic [1:0] ZRUN_MAX  = 2'd3;
	localparam logic [1:0] ZRUN_SC   = 2'd2;

	// one entry of work for the output side: an optional held byte, then zeros
	typedef struct packed {
		logic [7:0] held_byte;
		logic       has_held;
		logic [1:0] zeros;
		logic       last_unit;
		logic       first;
	} anbs_cmd_t;

endpackage

`default_nettype wire

FILE: sv/anbs_front.sv
`default_nettype none

module anbs_front
	import anbs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      accept,
	input  wire logic      action,
	input  wire logic [7:0] in_byte,
	output anbs_cmd_t      cmd,
	output logic           emit
);

	logic [1:0] zero_run_q;
	logic [7:0] held_byte_q;
	logic       held_valid_q;
	logic       in_unit_q;
	logic       first_due_q;

	logic [1:0] zero_run_d;
	logic [7:0] held_byte_d;
	logic       held_valid_d;
	logic       in_unit_d;
	logic       first_due_d;
	logic       is_zero;
	logic       is_start;

	assign is_zero  = (in_byte == BYTE_ZERO);
	assign is_start = (in_byte == BYTE_ONE) && (zero_run_q >= ZRUN_SC);

	always_comb begin
		zero_run_d    = zero_run_q;
		held_byte_d   = held_byte_q;
		held_valid_d  = held_valid_q;
		in_unit_d     = in_unit_q;
		first_due_d   = first_due_q;
		cmd.held_byte = held_byte_q;
		cmd.has_held  = 1'b0;
		cmd.zeros     = 2'd0;
		cmd.last_unit = 1'b0;
		cmd.first     = first_due_q;
		emit          = 1'b0;
		if (action) begin
			cmd.has_held  = 1'b1;
			cmd.last_unit = 1'b1;
			emit          = in_unit_q && held_valid_q;
			zero_run_d    = 2'd0;
			held_valid_d  = 1'b0;
			in_unit_d     = 1'b0;
			first_due_d   = 1'b0;
		end else if (is_zero) begin
			if (zero_run_q != ZRUN_MAX) begin
				zero_run_d = zero_run_q + 2'd1;
			end else if (in_unit_q) begin
				// saturated run: push the oldest zero out as payload
				cmd.has_held = 1'b1;
				emit         = held_valid_q;
				held_byte_d  = BYTE_ZERO;
				held_valid_d = 1'b1;
				if (held_valid_q) begin
					first_due_d = 1'b0;
				end
			end
		end else if (is_start) begin
			cmd.has_held  = 1'b1;
			cmd.last_unit = 1'b1;
			emit          = in_unit_q && held_valid_q;
			held_valid_d  = 1'b0;
			in_unit_d     = 1'b1;
			first_due_d   = 1'b1;
			zero_run_d    = 2'd0;
		end else begin
			if (in_unit_q) begin
				// false alarm: held zeros become payload, new byte is held
				cmd.has_held = held_valid_q;
				cmd.zeros    = zero_run_q;
				emit         = held_valid_q || (zero_run_q != 2'd0);
				held_byte_d  = in_byte;
				held_valid_d = 1'b1;
				if (emit) begin
					first_due_d = 1'b0;
				end
			end
			zero_run_d = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_run_q   <= 2'd0;
			held_valid_q <= 1'b0;
			in_unit_q    <= 1'b0;
			first_due_q  <= 1'b0;
		end else if (accept) begin
			zero_run_q   <= zero_run_d;
			held_valid_q <= held_valid_d;
			in_unit_q    <= in_unit_d;
			first_due_q  <= first_due_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_byte_q <= held_byte_d;
		end
	end

endmodule

`default_nettype wire

FILE: sv/anbs_queue.sv
`default_nettype none

module anbs_queue
	import anbs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire anbs_cmd_t push_cmd,
	input  wire logic      pop,
	output anbs_cmd_t      head,
	output logic           empty,
	output logic           full
);

	anbs_cmd_t           entry_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == QCNT_W'(QDEPTH));
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

FILE: sv/anbs_back.sv
`default_nettype none

module anbs_back
	import anbs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire anbs_cmd_t  head,
	input  wire logic       empty,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            first_of_unit,
	output logic            last_of_unit,
	output logic            last_in_run
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       first_q;
	logic       lastu_q;
	logic       lastr_q;

	logic [2:0] total;
	logic       load;
	logic       is_held;
	logic       final_one;

	assign total     = {2'b00, head.has_held} + {1'b0, head.zeros};
	assign final_one = ({1'b0, idx_q} == (total - 3'd1));
	assign is_held   = head.has_held && (idx_q == 2'd0);
	assign load      = !empty && (!valid_q || out_ready);
	assign pop       = load && final_one;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= final_one ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q  <= is_held ? head.held_byte : BYTE_ZERO;
			first_q <= head.first && (idx_q == 2'd0);
			lastu_q <= is_held && head.last_unit;
			lastr_q <= final_one;
		end
	end

	assign out_valid     = valid_q;
	assign out_byte      = byte_q;
	assign first_of_unit = first_q;
	assign last_of_unit  = lastu_q;
	assign last_in_run   = lastr_q;

endmodule

`default_nettype wire

FILE: sv/annexb_nal_unit_splitter.sv
// channel   dir  tdata             tuser                              tlast
// s_axis    in   in_byte [7:0]     action (0 byte, 1 flush)           -
// m_axis    out  out_byte [7:0]    [0] first_of_unit [1] last_in_run  last_of_unit
//
// One input byte per cycle; each byte is classified in the cycle it is taken.
// A byte yields 0 to 4 output words, drained at one word per cycle while the receiver
// is ready, from a 4-entry command queue, so ready drops only while that queue is full.
// Output words are registered from the head of the queue.
// arst_n clears all control state; the stream restarts before the first start code.
`default_nettype none

module annexb_nal_unit_splitter
	import anbs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  wire logic       s_axis_tuser,   // [0] action
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
	output logic [1:0]      m_axis_tuser,   // [0] first_of_unit, [1] last_in_run
	output logic            m_axis_tlast
);

	anbs_cmd_t cmd;
	anbs_cmd_t head;
	logic      emit;
	logic      accept;
	logic      empty;
	logic      full;
	logic      pop;

	assign s_axis_tready = !full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	anbs_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.action  (s_axis_tuser),
		.in_byte (s_axis_tdata),
		.cmd     (cmd),
		.emit    (emit)
	);

	anbs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept && emit),
		.push_cmd (cmd),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	anbs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.empty         (empty),
		.pop           (pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_byte      (m_axis_tdata),
		.first_of_unit (m_axis_tuser[0]),
		.last_of_unit  (m_axis_tlast),
		.last_in_run   (m_axis_tuser[1])
	);

endmodule

`default_nettype wire

FILE: sv/anbs_checker.sv
`default_nettype none
`include "annexb_nal_unit_splitter_macros.svh"

module anbs_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tvalid,
	input wire logic       s_axis_tready,
	input wire logic [7:0] s_axis_tdata,
	input wire logic       s_axis_tuser,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata,
	input wire logic [1:0] m_axis_tuser,
	input wire logic       m_axis_tlast
);

	// a stalled word holds
	`ANBS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// a unit only ends on the final word of its input byte
	`ANBS_ASSERT_NOW(a_last_ends_run, clk, arst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser[1])

	// backpressure at the input only while words wait at the output
	`ANBS_ASSERT_NOW(a_stall_has_output, clk, arst_n, !s_axis_tready, m_axis_tvalid)

endmodule

bind annexb_nal_unit_splitter anbs_checker u_anbs_checker (.*);

`default_nettype wire

FILE: dv/annexb_nal_unit_splitter_tb.sv
`timescale 1ns / 100ps

module annexb_nal_unit_splitter_tb;

	localparam logic ACT_BYTE  = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;
	localparam int   CYCLE_LIMIT = 200000;
	localparam int   MAX_REPORTS = 10;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last_unit;
		logic       last_run;
	} nal_word_t;

	// Tracks the splitter state and the NAL payload words it must produce
	class nal_scoreboard;
		logic [1:0] zero_run;
		logic [7:0] held_byte;
		logic       held_valid;
		logic       in_unit;
		logic       first_due;
		nal_word_t  run_words[$];
		nal_word_t  expected_words[$];
		int         mismatches;
		int         words_checked;
		int         items;
		int         flushes;
		int         start_codes;
		int         max_run;

		function new();
			zero_run      = 2'd0;
			held_byte     = 8'h00;
			held_valid    = 1'b0;
			in_unit       = 1'b0;
			first_due     = 1'b0;
			mismatches    = 0;
			words_checked = 0;
			items         = 0;
			flushes       = 0;
			start_codes   = 0;
			max_run       = 0;
		endfunction

		function void emit(logic [7:0] b, logic last_unit);
			nal_word_t w;
			w.data      = b;
			w.first     = first_due;
			w.last_unit = last_unit;
			w.last_run  = 1'b0;
			run_words.push_back(w);
			first_due = 1'b0;
		endfunction

		// release the held byte, hold the new one
		function void take_payload(logic [7:0] b);
			if (held_valid)
				emit(held_byte, 1'b0);
			held_byte  = b;
			held_valid = 1'b1;
		endfunction

		function void note_input(logic act, logic [7:0] b);
			run_words.delete();
			items++;
			if (act == ACT_FLUSH) begin
				flushes++;
				if (in_unit && held_valid)
					emit(held_byte, 1'b1);
				zero_run   = 2'd0;
				held_valid = 1'b0;
				in_unit    = 1'b0;
				first_due  = 1'b0;
			end else if (b == anbs_pkg::BYTE_ZERO) begin
				// past three zeros the oldest one becomes payload
				if (zero_run < anbs_pkg::ZRUN_MAX)
					zero_run++;
				else if (in_unit)
					take_payload(anbs_pkg::BYTE_ZERO);
			end else if (b == anbs_pkg::BYTE_ONE && zero_run >= anbs_pkg::ZRUN_SC) begin
				start_codes++;
				if (in_unit && held_valid)
					emit(held_byte, 1'b1);
				held_valid = 1'b0;
				in_unit    = 1'b1;
				first_due  = 1'b1;
				zero_run   = 2'd0;
			end else begin
				if (in_unit) begin
					for (int i = 0; i < zero_run; i++)
						take_payload(anbs_pkg::BYTE_ZERO);
					take_payload(b);
				end
				zero_run = 2'd0;
			end
			if (run_words.size() > 0)
				run_words[run_words.size() - 1].last_run = 1'b1;
			if (run_words.size() > max_run)
				max_run = run_words.size();
			foreach (run_words[i])
				expected_words.push_back(run_words[i]);
		endfunction

		function void check_result(nal_word_t got);
			nal_word_t want;
			words_checked++;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("ERROR: unexpected word data=%02h first=%0b last_unit=%0b last_run=%0b",
						got.data, got.first, got.last_unit, got.last_run);
				return;
			end
			want = expected_words.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$write("ERROR: word %0d expected data=%02h first=%0b last_unit=%0b last_run=%0b,",
						words_checked, want.data, want.first, want.last_unit, want.last_run);
					$display(" got data=%02h first=%0b last_unit=%0b last_run=%0b",
						got.data, got.first, got.last_unit, got.last_run);
				end
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		function void finish_check();
			if (expected_words.size() != 0) begin
				mismatches += expected_words.size();
				$display("ERROR: %0d expected words never arrived", expected_words.size());
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       s_axis_tuser = ACT_BYTE;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic       m_axis_tlast;

	nal_scoreboard sb;
	int src_idle_pct  = 0;
	int sink_idle_pct = 0;
	int stall_cycles  = 0;
	int items_sent    = 0;
	int cycle_count   = 0;

	annexb_nal_unit_splitter DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ERROR: timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver: a pending hold-off wins over random backpressure
	always @(negedge clk) begin
		if (stall_cycles > 0) begin
			m_axis_tready = 1'b0;
			stall_cycles--;
		end else begin
			m_axis_tready = ($urandom_range(99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result({m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]});
	end

	// returns at the rising edge that takes the word
	task automatic send_item(input logic act, input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = act;
		s_axis_tdata  = b;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_input(act, b);
		items_sent++;
	endtask

	task automatic send_bytes(input logic [7:0] seq[$]);
		foreach (seq[i])
			send_item(ACT_BYTE, seq[i]);
	endtask

	// hold the input until every expected word is out
	task automatic drain_output();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] payload_byte();
		int pick;
		pick = $urandom_range(19);
		if (pick < 3)
			return anbs_pkg::BYTE_ZERO;
		else if (pick == 3)
			return anbs_pkg::BYTE_ONE;
		else if (pick == 4)
			return 8'h03;
		return 8'($urandom_range(255));
	endfunction

	// mostly well-formed units with random payload, some noise and flushes
	task automatic send_random_stream(input int target);
		int nz;
		int plen;
		while (items_sent < target) begin
			case ($urandom_range(19))
				0: send_item(ACT_FLUSH, 8'($urandom_range(255)));
				1: repeat ($urandom_range(1, 3)) send_item(ACT_BYTE, 8'($urandom_range(255)));
				default: begin
					if ($urandom_range(9) < 6)
						nz = 2;
					else if ($urandom_range(3) == 0)
						nz = $urandom_range(4, 6);
					else
						nz = 3;
					repeat (nz) send_item(ACT_BYTE, anbs_pkg::BYTE_ZERO);
					send_item(ACT_BYTE, anbs_pkg::BYTE_ONE);
					plen = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 10);
					repeat (plen) send_item(ACT_BYTE, payload_byte());
				end
			endcase
		end
	endtask

	initial begin
		sb = new();
		src_idle_pct  = 20;
		sink_idle_pct = 71;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// junk before the first start code, then a three-byte start code
		send_bytes('{8'hAB, 8'h00, 8'h00, 8'h01, 8'hFF});
		// lone zero before 01 is payload
		send_bytes('{8'h00, 8'h01, 8'h80});
		// three zeros and a non-01 byte: held byte plus three zeros out at once
		send_bytes('{8'h00, 8'h00, 8'h00, 8'h7F});
		// long zero run ending in a four-byte start code
		send_bytes('{8'h00, 8'h00, 8'h00, 8'h00, 8'h01});
		// empty unit, then a one-byte unit closed by flush
		send_bytes('{8'h00, 8'h00, 8'h01, 8'h55});
		send_item(ACT_FLUSH, 8'hFF);
		// trailing zeros outside any unit, then flush with nothing held
		send_bytes('{8'h00, 8'h00});
		send_item(ACT_FLUSH, 8'h00);

		send_random_stream(100);
		drain_output();

		src_idle_pct  = 71;
		sink_idle_pct = 20;
		send_random_stream(190);
		drain_output();

		src_idle_pct  = 0;
		sink_idle_pct = 0;
		stall_cycles  = 60;
		send_random_stream(240);
		stall_cycles  = 80;
		send_random_stream(280);
		drain_output();
		repeat (20) @(posedge clk);

		sb.finish_check();
		$display("Run covered %0d inputs (%0d flushes, %0d start codes) and %0d output words,",
			sb.items, sb.flushes, sb.start_codes, sb.words_checked);
		$display("with up to %0d words from one input, under idle, stall and hold-off phases.",
			sb.max_run);
		if (sb.mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
